>>> design/gnms_pkg.sv
package gnms_pkg;

    localparam int DEFAULT_MAX_WIDTH = 1024;
    localparam int DEFAULT_MAG_BITS  = 16;

    localparam int CFG_BITS = 11;
    localparam logic [CFG_BITS-1:0] WIDTH_RESET = 11'd640;
    localparam int MIN_WIDTH = 3;

    localparam int IN_MAG_BITS = 16;
    localparam int ANG_BITS    = 16;
    localparam int X_BITS      = 10;
    localparam int Y_BITS      = 16;

    // Q3.13 radians, PI and the band edges at odd multiples of PI/8
    localparam logic signed [ANG_BITS:0] ANG_PI = 17'sd25736;
    localparam logic signed [ANG_BITS:0] ANG_B1 = 17'sd3217;
    localparam logic signed [ANG_BITS:0] ANG_B3 = 17'sd9651;
    localparam logic signed [ANG_BITS:0] ANG_B5 = 17'sd16085;
    localparam logic signed [ANG_BITS:0] ANG_B7 = 17'sd22519;

    typedef logic [1:0] dir_t;
    localparam dir_t DIR_HORZ = 2'd0;
    localparam dir_t DIR_DIAG = 2'd1;
    localparam dir_t DIR_VERT = 2'd2;
    localparam dir_t DIR_ANTI = 2'd3;

    // position of the judged center pixel, already in output form
    typedef struct packed {
        logic              emit;
        logic [X_BITS-1:0] x;
        logic [Y_BITS-1:0] y;
    } pos_t;

    function automatic dir_t quantize_angle(input logic [ANG_BITS-1:0] raw);
        logic signed [ANG_BITS:0] t;
        dir_t d;
        t = signed'({raw[ANG_BITS-1], raw});
        if (t < 0) begin
            t = t + ANG_PI;
        end
        if (t >= ANG_B1 && t < ANG_B3) begin
            d = DIR_DIAG;
        end else if (t >= ANG_B3 && t < ANG_B5) begin
            d = DIR_VERT;
        end else if (t >= ANG_B5 && t < ANG_B7) begin
            d = DIR_ANTI;
        end else begin
            d = DIR_HORZ;
        end
        return d;
    endfunction

endpackage

>>> design/gradient_nonmax_suppression.sv
// Gradient non-maximum suppression, four directions, streaming.
// Input: one pixel word per handshake on s_valid/s_ready, raster order,
// s_frame_start set on the first pixel of a frame. Output: one word on
// m_valid/m_ready for every interior pixel: m_peak for the pixel one row up
// and one column left of the current input, at m_pixel_x/m_pixel_y.
// Pixels in the first two rows or first two columns of the input give no
// word, so the last row and column of an image are never judged.
// cfg_wr_en/cfg_wr_data set the row width (clamped to 3..MAX_WIDTH); write
// it only while the block is idle.
// Throughput: one pixel per clock while the receiver keeps up. The line
// buffer is read and the pixel enters the read stage at the accepting edge;
// the window compare loads the output register when the read stage advances.
// When the receiver stalls, the output register holds its word while one
// more pixel waits in the read stage; s_ready drops only when both are full.
// Pixels that give no word pass through even while the output is stalled.
// Reset (synchronous, aresetn low) sets the width to 640, clears counters,
// window and valids; line buffers are not cleared and need no pass.
module gradient_nonmax_suppression #(
    parameter int MAX_WIDTH = gnms_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAG_BITS  = gnms_pkg::DEFAULT_MAG_BITS
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [gnms_pkg::CFG_BITS-1:0]         cfg_wr_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_frame_start,
    input  logic [gnms_pkg::IN_MAG_BITS-1:0]      s_magnitude,
    input  logic signed [gnms_pkg::ANG_BITS-1:0]  s_angle,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_peak,
    output logic [gnms_pkg::X_BITS-1:0]           m_pixel_x,
    output logic [gnms_pkg::Y_BITS-1:0]           m_pixel_y
);

    localparam int COL_BITS = $clog2(MAX_WIDTH);
    localparam int EXT_BITS = (MAG_BITS > gnms_pkg::IN_MAG_BITS) ? MAG_BITS
                                                                 : gnms_pkg::IN_MAG_BITS;

    logic                  accept, advance;
    logic [COL_BITS-1:0]   col0;
    gnms_pkg::pos_t        pos0;
    logic [EXT_BITS-1:0]   mag_ext;
    logic [MAG_BITS-1:0]   mag0;

    logic                  v1_reg, v1_next;
    gnms_pkg::pos_t        pos1_reg;
    logic [COL_BITS-1:0]   col1_reg;
    logic [MAG_BITS-1:0]   mag1_reg;
    gnms_pkg::dir_t        dir1_reg;

    logic [MAG_BITS-1:0]   rd_older, rd_newer;
    gnms_pkg::dir_t        rd_dir;
    logic                  peak;

    logic                  m_valid_reg, m_valid_next;
    logic                  m_peak_reg;
    logic [gnms_pkg::X_BITS-1:0] m_pixel_x_reg;
    logic [gnms_pkg::Y_BITS-1:0] m_pixel_y_reg;

    assign mag_ext = EXT_BITS'(s_magnitude);
    assign mag0    = mag_ext[MAG_BITS-1:0];

    // read stage moves on unless it carries a word and the output is full and not taken
    assign advance = v1_reg && (!pos1_reg.emit || !m_valid_reg || m_ready);
    assign s_ready = !v1_reg || advance;
    assign accept  = s_valid && s_ready;

    gnms_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .frame_start (s_frame_start),
        .col         (col0),
        .pos         (pos0)
    );

    gnms_line_buf #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAG_BITS  (MAG_BITS)
    ) u_line_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (accept),
        .rd_addr  (col0),
        .wr_en    (advance),
        .wr_addr  (col1_reg),
        .wr_older (rd_newer),
        .wr_newer (mag1_reg),
        .wr_dir   (dir1_reg),
        .rd_older (rd_older),
        .rd_newer (rd_newer),
        .rd_dir   (rd_dir)
    );

    gnms_window #(
        .MAG_BITS (MAG_BITS)
    ) u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .cur0      (rd_older),
        .cur1      (rd_newer),
        .cur2      (mag1_reg),
        .dir_above (rd_dir),
        .peak      (peak)
    );

    always_comb begin
        v1_next = v1_reg;
        if (accept) begin
            v1_next = 1'b1;
        end else if (advance) begin
            v1_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (advance && pos1_reg.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            v1_reg      <= v1_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pos1_reg <= pos0;
            col1_reg <= col0;
            mag1_reg <= mag0;
            dir1_reg <= gnms_pkg::quantize_angle(s_angle);
        end
        if (advance && pos1_reg.emit) begin
            m_peak_reg    <= peak;
            m_pixel_x_reg <= pos1_reg.x;
            m_pixel_y_reg <= pos1_reg.y;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_peak    = m_peak_reg;
    assign m_pixel_x = m_pixel_x_reg;
    assign m_pixel_y = m_pixel_y_reg;

    a_word_from_stage : assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(v1_reg && pos1_reg.emit))
        else $error("output word without a judged pixel");

    a_stall_cause : assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (v1_reg && m_valid && !m_ready))
        else $error("input stalled while a stage is free");

    a_interior_x : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_pixel_x != '0 && m_pixel_y != '0))
        else $error("border pixel judged");

endmodule

>>> design/gnms_ctrl.sv
module gnms_ctrl #(
    parameter int MAX_WIDTH = gnms_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [gnms_pkg::CFG_BITS-1:0]      cfg_wr_data,
    input  logic                               accept,
    input  logic                               frame_start,
    output logic [$clog2(MAX_WIDTH)-1:0]       col,
    output gnms_pkg::pos_t                     pos
);

    localparam int COL_BITS = $clog2(MAX_WIDTH);
    localparam int WB = (gnms_pkg::CFG_BITS > COL_BITS + 1) ? gnms_pkg::CFG_BITS
                                                             : COL_BITS + 1;

    logic [gnms_pkg::CFG_BITS-1:0] width_reg;
    logic [COL_BITS-1:0]           col_reg, col_next;
    logic [gnms_pkg::Y_BITS-1:0]   row_reg, row_next;

    logic [WB-1:0]                 width_cfg, width_use;
    logic [COL_BITS-1:0]           col_cur;
    logic [gnms_pkg::Y_BITS-1:0]   row_cur;
    logic [WB-1:0]                 col_inc, x_full;

    always_comb begin
        width_cfg = WB'(width_reg);
        if (width_cfg < WB'(gnms_pkg::MIN_WIDTH)) begin
            width_use = WB'(gnms_pkg::MIN_WIDTH);
        end else if (width_cfg > WB'(MAX_WIDTH)) begin
            width_use = WB'(MAX_WIDTH);
        end else begin
            width_use = width_cfg;
        end

        col_cur = frame_start ? '0 : col_reg;
        row_cur = frame_start ? '0 : row_reg;
        // a width shrunk mid-row wraps the column at once
        if (WB'(col_cur) >= width_use) begin
            col_cur = '0;
        end

        col_inc  = WB'(col_cur) + WB'(1);
        col_next = col_inc[COL_BITS-1:0];
        row_next = row_cur;
        if (col_inc >= width_use) begin
            col_next = '0;
            if (row_cur != '1) begin
                row_next = row_cur + 1'b1;
            end
        end

        x_full   = WB'(col_cur) - WB'(1);
        pos.emit = (row_cur >= 2) && (WB'(col_cur) >= WB'(2));
        pos.x    = x_full[gnms_pkg::X_BITS-1:0];
        pos.y    = row_cur - 1'b1;
        col      = col_cur;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= gnms_pkg::WIDTH_RESET;
            col_reg   <= '0;
            row_reg   <= '0;
        end else begin
            if (cfg_wr_en) begin
                width_reg <= cfg_wr_data;
            end
            if (accept) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

endmodule

>>> design/gnms_line_buf.sv
module gnms_line_buf #(
    parameter int MAX_WIDTH = gnms_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAG_BITS  = gnms_pkg::DEFAULT_MAG_BITS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
    input  logic                         wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
    input  logic [MAG_BITS-1:0]          wr_older,
    input  logic [MAG_BITS-1:0]          wr_newer,
    input  gnms_pkg::dir_t               wr_dir,
    output logic [MAG_BITS-1:0]          rd_older,
    output logic [MAG_BITS-1:0]          rd_newer,
    output gnms_pkg::dir_t               rd_dir
);

    logic [MAG_BITS-1:0]  older_ram_reg [0:MAX_WIDTH-1];
    logic [MAG_BITS-1:0]  newer_ram_reg [0:MAX_WIDTH-1];
    gnms_pkg::dir_t       dir_ram_reg   [0:MAX_WIDTH-1];

    logic [MAG_BITS-1:0]  older_q_reg, newer_q_reg;
    gnms_pkg::dir_t       dir_q_reg;

    // read and write of the same column at one edge: forward the write word
    logic                 byp_reg;
    logic [MAG_BITS-1:0]  byp_older_reg, byp_newer_reg;
    gnms_pkg::dir_t       byp_dir_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            older_ram_reg[wr_addr] <= wr_older;
            newer_ram_reg[wr_addr] <= wr_newer;
            dir_ram_reg[wr_addr]   <= wr_dir;
        end
        if (rd_en) begin
            older_q_reg   <= older_ram_reg[rd_addr];
            newer_q_reg   <= newer_ram_reg[rd_addr];
            dir_q_reg     <= dir_ram_reg[rd_addr];
            byp_older_reg <= wr_older;
            byp_newer_reg <= wr_newer;
            byp_dir_reg   <= wr_dir;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_reg <= 1'b0;
        end else if (rd_en) begin
            byp_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_older = byp_reg ? byp_older_reg : older_q_reg;
    assign rd_newer = byp_reg ? byp_newer_reg : newer_q_reg;
    assign rd_dir   = byp_reg ? byp_dir_reg   : dir_q_reg;

endmodule

>>> design/gnms_window.sv
module gnms_window #(
    parameter int MAG_BITS = gnms_pkg::DEFAULT_MAG_BITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  logic [MAG_BITS-1:0] cur0,
    input  logic [MAG_BITS-1:0] cur1,
    input  logic [MAG_BITS-1:0] cur2,
    input  gnms_pkg::dir_t      dir_above,
    output logic                peak
);

    // wm_reg[0..2]: left column rows 0..2, wm_reg[3..5]: middle column
    logic [MAG_BITS-1:0] wm_reg [0:5];
    gnms_pkg::dir_t      wd_reg [0:1];

    logic [MAG_BITS-1:0] c, a, b;

    always_comb begin
        c = wm_reg[4];
        case (wd_reg[0])
            gnms_pkg::DIR_HORZ: begin
                a = cur1;
                b = wm_reg[1];
            end
            gnms_pkg::DIR_DIAG: begin
                a = cur2;
                b = wm_reg[0];
            end
            gnms_pkg::DIR_VERT: begin
                a = wm_reg[5];
                b = wm_reg[3];
            end
            default: begin
                a = wm_reg[2];
                b = cur0;
            end
        endcase
        peak = (c >= a && c > b) || (c > a && c >= b);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) begin
                wm_reg[i] <= '0;
            end
            wd_reg[0] <= gnms_pkg::DIR_HORZ;
            wd_reg[1] <= gnms_pkg::DIR_HORZ;
        end else if (step) begin
            wm_reg[0] <= wm_reg[3];
            wm_reg[1] <= wm_reg[4];
            wm_reg[2] <= wm_reg[5];
            wm_reg[3] <= cur0;
            wm_reg[4] <= cur1;
            wm_reg[5] <= cur2;
            wd_reg[1] <= wd_reg[0];
            wd_reg[0] <= dir_above;
        end
    end

endmodule

>>> test/tb_gradient_nonmax_suppression.sv
`timescale 1ns / 1ps

module tb_gradient_nonmax_suppression;

    import gnms_pkg::*;

    localparam int LINE_MAX       = DEFAULT_MAX_WIDTH;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 6;
    localparam int RANDOM_PIXELS  = 900;

    typedef struct packed {
        logic              peak;
        logic [X_BITS-1:0] x;
        logic [Y_BITS-1:0] y;
    } judged_t;

    class nms_scoreboard;
        bit [CFG_BITS-1:0]    width_reg;
        bit [IN_MAG_BITS-1:0] older_row [LINE_MAX];
        bit [IN_MAG_BITS-1:0] newer_row [LINE_MAX];
        dir_t                 dir_row [LINE_MAX];
        bit [IN_MAG_BITS-1:0] win_mag [6];
        dir_t                 win_dir [2];
        int unsigned          col_cnt;
        int unsigned          row_cnt;
        judged_t              expected_words [$];
        int                   fail_count;

        function new();
            width_reg = WIDTH_RESET;
            col_cnt = 0;
            row_cnt = 0;
            fail_count = 0;
        endfunction

        function void set_width(bit [CFG_BITS-1:0] v);
            width_reg = v;
        endfunction

        // fold into 0..PI, then bands at odd multiples of PI/8
        function dir_t quantize(bit [ANG_BITS-1:0] raw);
            int t;
            t = int'($signed(raw));
            if (t < 0) t = t + int'(ANG_PI);
            if (t >= int'(ANG_B1) && t < int'(ANG_B3)) return DIR_DIAG;
            if (t >= int'(ANG_B3) && t < int'(ANG_B5)) return DIR_VERT;
            if (t >= int'(ANG_B5) && t < int'(ANG_B7)) return DIR_ANTI;
            return DIR_HORZ;
        endfunction

        function void note_pixel(bit fs, bit [IN_MAG_BITS-1:0] mag,
                                 bit [ANG_BITS-1:0] ang);
            int unsigned          w;
            int unsigned          col;
            bit [IN_MAG_BITS-1:0] m [3][3];
            bit [IN_MAG_BITS-1:0] c;
            bit [IN_MAG_BITS-1:0] a;
            bit [IN_MAG_BITS-1:0] b;
            judged_t              j;
            w = (width_reg < MIN_WIDTH) ? MIN_WIDTH
              : ((width_reg > LINE_MAX) ? LINE_MAX : width_reg);
            if (fs) begin
                col_cnt = 0;
                row_cnt = 0;
            end
            // width shrunk under a partial row
            if (col_cnt >= w) col_cnt = 0;
            col = col_cnt;
            win_dir[1] = win_dir[0];
            win_dir[0] = dir_row[col];
            for (int r = 0; r < 3; r++) begin
                m[r][0] = win_mag[r];
                m[r][1] = win_mag[3 + r];
            end
            m[0][2] = older_row[col];
            m[1][2] = newer_row[col];
            m[2][2] = mag;
            if (row_cnt >= 2 && col >= 2) begin
                c = m[1][1];
                // m[row][col], center at [1][1]
                case (win_dir[1])
                    DIR_HORZ: begin
                        a = m[1][2];
                        b = m[1][0];
                    end
                    DIR_DIAG: begin
                        a = m[2][2];
                        b = m[0][0];
                    end
                    DIR_VERT: begin
                        a = m[2][1];
                        b = m[0][1];
                    end
                    default: begin
                        a = m[2][0];
                        b = m[0][2];
                    end
                endcase
                j.peak = (c >= a && c > b) || (c > a && c >= b);
                j.x = X_BITS'(col - 1);
                j.y = Y_BITS'(row_cnt - 1);
                expected_words.push_back(j);
            end
            for (int r = 0; r < 3; r++) begin
                win_mag[r] = m[r][1];
                win_mag[3 + r] = m[r][2];
            end
            older_row[col] = m[1][2];
            newer_row[col] = mag;
            dir_row[col] = quantize(ang);
            col_cnt = col + 1;
            if (col_cnt >= w) begin
                col_cnt = 0;
                if (row_cnt < 65535) row_cnt++;
            end
        endfunction

        function void log_failure(string msg);
            fail_count++;
            if (fail_count <= 10) $display("%s", msg);
        endfunction

        function void check_word(logic pk, logic [X_BITS-1:0] x, logic [Y_BITS-1:0] y);
            judged_t e;
            if (expected_words.size() == 0) begin
                log_failure($sformatf("unexpected word: peak=%0d x=%0d y=%0d", pk, x, y));
                return;
            end
            e = expected_words.pop_front();
            if (e.peak !== pk || e.x !== x || e.y !== y) begin
                log_failure($sformatf(
                    "word mismatch: expected peak=%0d x=%0d y=%0d, got peak=%0d x=%0d y=%0d",
                    e.peak, e.x, e.y, pk, x, y));
            end
        endfunction

        function void flush_missing();
            judged_t e;
            while (expected_words.size() != 0) begin
                e = expected_words.pop_front();
                log_failure($sformatf("missing word: expected peak=%0d x=%0d y=%0d",
                                      e.peak, e.x, e.y));
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       cfg_wr_en = 1'b0;
    logic [CFG_BITS-1:0]        cfg_wr_data = '0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic                       s_frame_start = 1'b0;
    logic [IN_MAG_BITS-1:0]     s_magnitude = '0;
    logic signed [ANG_BITS-1:0] s_angle = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic                       m_peak;
    logic [X_BITS-1:0]          m_pixel_x;
    logic [Y_BITS-1:0]          m_pixel_y;

    logic [15:0] rx_mask = 16'hFFFF;
    logic [3:0]  rx_pos = 4'd0;
    int          stalled_cycles = 0;

    nms_scoreboard sb = new();

    // directed frame at width 5, then width 3 written mid-row
    int probe_mag [24] = '{0, 65535, 100, 100, 7,
                           100, 100, 65535, 100, 0,
                           100, 100, 100, 65535, 65535,
                           100, 0, 65535,
                           100, 100, 100, 65535, 0, 100};
    int probe_ang [24] = '{-32768, 32767, -1, 0, 3216,
                           9650, 3217, 9651, 16085, 16084,
                           22518, 22519, -25736, -12868, 25736,
                           -3217, -9651, -16085,
                           -22519, -25735, 25735, 12868, 8000, -8000};

    gradient_nonmax_suppression uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_frame_start (s_frame_start),
        .s_magnitude   (s_magnitude),
        .s_angle       (s_angle),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_peak        (m_peak),
        .m_pixel_x     (m_pixel_x),
        .m_pixel_y     (m_pixel_y)
    );

    always #2 aclk = ~aclk;

    always @(negedge aclk) begin
        m_ready <= rx_mask[rx_pos];
        rx_pos <= rx_pos + 4'd1;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_pixel(s_frame_start, s_magnitude, s_angle);
            if (m_valid && m_ready) sb.check_word(m_peak, m_pixel_x, m_pixel_y);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stalled_cycles <= 0;
        end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
        end
    end

    function automatic logic [IN_MAG_BITS-1:0] random_magnitude(int mode);
        case (mode)
            1: return IN_MAG_BITS'($urandom_range(0, 3));
            2: begin
                case ($urandom_range(0, 3))
                    0: return '0;
                    1: return 16'hFFFF;
                    2: return 16'hFFFE;
                    default: return IN_MAG_BITS'($urandom);
                endcase
            end
            default: return IN_MAG_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [ANG_BITS-1:0] random_angle();
        int band_edges [5] = '{3217, 9651, 16085, 22519, 25736};
        int pick;
        int v;
        pick = $urandom_range(0, 7);
        if (pick == 0) begin
            v = $urandom_range(0, 65535);
        end else if (pick == 1) begin
            v = band_edges[$urandom_range(0, 4)] - int'($urandom_range(0, 1));
            if ($urandom_range(0, 1) == 1) v = -v;
        end else begin
            v = int'($urandom_range(0, 51472)) - 25736;
        end
        return ANG_BITS'(v);
    endfunction

    task automatic send_pixel(input logic fs, input logic [IN_MAG_BITS-1:0] mag,
                              input logic [ANG_BITS-1:0] ang);
        @(negedge aclk);
        s_valid <= 1'b1;
        s_frame_start <= fs;
        s_magnitude <= mag;
        s_angle <= ang;
        do @(posedge aclk); while (s_ready !== 1'b1);
    endtask

    task automatic idle_sender(input int n);
        repeat (n) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        // words with no result may still be in flight
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic start_phase(input logic [CFG_BITS-1:0] width, input bit full_rate);
        wait_drained();
        if (full_rate) begin
            rx_mask = 16'hFFFF;
        end else begin
            case ($urandom_range(0, 3))
                0: rx_mask = 16'hFFFF;
                1: rx_mask = 16'($urandom);
                2: rx_mask = 16'($urandom & $urandom);
                default: rx_mask = 16'($urandom | $urandom);
            endcase
            if (rx_mask == 16'h0000) rx_mask = 16'h0001;
        end
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= width;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_width(width);
    endtask

    // one frame: frame_start on the first word, rare stray frame starts after
    task automatic send_stream(input int count, input int mag_mode, input bit bursty);
        int   i;
        int   burst_left;
        logic fs;
        burst_left = 0;
        for (i = 0; i < count; i++) begin
            if (bursty && burst_left == 0) begin
                if ($urandom_range(0, 15) == 0) wait_drained();
                idle_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
                burst_left = $urandom_range(1, 32);
            end
            burst_left--;
            fs = (i == 0) ? 1'b1 : (bursty && $urandom_range(0, 99) == 0);
            send_pixel(fs, random_magnitude(mag_mode), random_angle());
        end
    endtask

    initial begin
        int sent;
        int w;
        int w_used;
        int n;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        start_phase(11'd5, 1'b0);
        for (int i = 0; i < 24; i++) begin
            if (i == 18) start_phase(11'd3, 1'b0);
            send_pixel(i == 0, 16'(probe_mag[i]), 16'(probe_ang[i]));
        end

        // clamps to the full line length
        start_phase(11'd2047, 1'b0);
        send_stream(LINE_MAX + 6, 0, 1'b1);

        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            case ($urandom_range(0, 9))
                0: w = $urandom_range(0, 2);
                1: w = $urandom_range(13, 64);
                default: w = $urandom_range(3, 12);
            endcase
            w_used = (w < MIN_WIDTH) ? MIN_WIDTH : w;
            n = $urandom_range(2, 6) * w_used + $urandom_range(0, w_used - 1);
            start_phase(CFG_BITS'(w), 1'b0);
            send_stream(n, $urandom_range(0, 2), 1'b1);
            sent += n;
        end

        wait_drained();
        sb.flush_missing();
        if (sb.fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
